// ===== rtl/core/msts_pkg.sv =====
package msts_pkg;

  typedef enum logic [4:0] {
    TP_IDLE   = 5'b00001,
    TP_CMD    = 5'b00010,
    TP_DATA   = 5'b00100,
    TP_STATUS = 5'b01000,
    TP_RETRY  = 5'b10000
  } tp_t;

  typedef enum logic [3:0] {
    RC_IDLE    = 4'b0001,
    RC_RESET   = 4'b0010,
    RC_CLR_IN  = 4'b0100,
    RC_CLR_OUT = 4'b1000
  } rc_t;

  localparam logic [1:0] REQ_SUBMIT = 2'd0;
  localparam logic [1:0] REQ_BULK   = 2'd1;
  localparam logic [1:0] REQ_CTRL   = 2'd2;
  localparam logic [1:0] REQ_ABORT  = 2'd3;

  localparam logic [1:0] OC_OK    = 2'd0;
  localparam logic [1:0] OC_FAIL  = 2'd1;
  localparam logic [1:0] OC_STALL = 2'd2;

  localparam logic [3:0] A_CBW     = 4'd0;
  localparam logic [3:0] A_ADSC    = 4'd1;
  localparam logic [3:0] A_DIAG    = 4'd2;
  localparam logic [3:0] A_SRESET  = 4'd3;
  localparam logic [3:0] A_DATA    = 4'd4;
  localparam logic [3:0] A_CSW     = 4'd5;
  localparam logic [3:0] A_CLEAR   = 4'd6;
  localparam logic [3:0] A_UNSTALL = 4'd7;
  localparam logic [3:0] A_ABORT   = 4'd8;
  localparam logic [3:0] A_DONE    = 4'd9;
  localparam logic [3:0] A_REJECT  = 4'd10;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_UFI   = 3'd1;
  localparam logic [2:0] REG_IN_EP = 3'd2;
  localparam logic [2:0] REG_OUT_EP = 3'd3;
  localparam logic [2:0] REG_IFNUM = 3'd4;

  localparam logic [15:0] CBW_LEN   = 16'd31;
  localparam logic [15:0] CSW_LEN   = 16'd13;
  localparam logic [4:0]  CB_CMD_LEN = 5'd12;
  localparam logic [31:0] CSW_SIG   = 32'h53425355;

  typedef struct packed {
    logic [31:0] residue;
    logic [1:0]  status;
    logic [31:0] tag;
    logic [15:0] offset;
    logic [15:0] length;
    logic [7:0]  endpoint;
    logic [3:0]  action;
  } act_t;

  typedef struct packed {
    logic           rdy;
    logic [2:0]     n;
    act_t [3:0]     a;
  } bun_t;

  function automatic act_t mk(logic [3:0] act, logic [7:0] ep, logic [15:0] len,
                              logic [15:0] off, logic [31:0] tag, logic [1:0] st,
                              logic [31:0] res);
    act_t x;
    x.action = act;
    x.endpoint = ep;
    x.length = len;
    x.offset = off;
    x.tag = tag;
    x.status = st;
    x.residue = res;
    return x;
  endfunction

  function automatic bun_t put(bun_t b, act_t x);
    bun_t r;
    r = b;
    r.a[r.n[1:0]] = x;
    r.n = r.n + 3'd1;
    return r;
  endfunction

endpackage

// ===== rtl/core/msts_front.sv =====
module msts_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           req_type,
  input  logic [31:0]          data_length,
  input  logic                 dir_in,
  input  logic                 has_buffer,
  input  logic [4:0]           command_length,
  input  logic [7:0]           done_endpoint,
  input  logic [1:0]           xfer_outcome,
  input  logic [31:0]          bytes_moved,
  input  logic [31:0]          status_signature,
  input  logic [31:0]          status_tag,
  input  logic [7:0]           status_code,
  input  logic [31:0]          status_residue,
  input  logic                 mode_bulk_only,
  input  logic                 subclass_ufi,
  input  logic [7:0]           in_endpoint,
  input  logic [7:0]           out_endpoint,
  output logic                 push,
  output msts_pkg::bun_t       bundle
);
  import msts_pkg::*;

  tp_t         tp, tp_next;
  rc_t         rp, rp_next;
  logic [31:0] tag, tag_next;
  logic [31:0] slen, slen_next;
  logic        sdir, sdir_next;
  logic        sbuf, sbuf_next;
  logic        cpend, cpend_next;

  bun_t        bn;
  logic [1:0]  oc;
  logic        okc;
  logic [7:0]  dep;
  logic        fail;
  logic        startrec;
  logic        csw_ok;
  logic [31:0] resid;
  logic [4:0]  clen;

  always_comb begin
    bn = '0;
    tp_next = tp;
    rp_next = rp;
    tag_next = tag;
    slen_next = slen;
    sdir_next = sdir;
    sbuf_next = sbuf;
    cpend_next = cpend;
    fail = 1'b0;
    startrec = 1'b0;
    oc = (xfer_outcome == 2'd3) ? OC_FAIL : xfer_outcome;
    okc = (oc == OC_OK);
    dep = sdir ? in_endpoint : out_endpoint;
    resid = (bytes_moved <= slen) ? slen - bytes_moved : 32'd0;
    clen = (subclass_ufi || command_length > CB_CMD_LEN) ? CB_CMD_LEN : command_length;
    csw_ok = okc && bytes_moved == {16'd0, CSW_LEN} && status_signature == CSW_SIG &&
             status_tag == tag && status_code <= 8'd2 && status_residue <= slen;
    unique case (req_type)
      REQ_SUBMIT: begin
        if (in_endpoint == 8'd0 || tp != TP_IDLE) begin
          bn = put(bn, mk(A_REJECT, 8'd0, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
        end else begin
          tag_next = (tag == 32'hFFFF_FFFF) ? 32'd1 : tag + 32'd1;
          slen_next = data_length;
          sdir_next = dir_in;
          sbuf_next = has_buffer;
          tp_next = TP_CMD;
          if (mode_bulk_only) begin
            bn = put(bn, mk(A_CBW, out_endpoint, CBW_LEN, 16'd0, tag_next, 2'd0, 32'd0));
          end else begin
            bn = put(bn, mk(A_ADSC, 8'd0, {11'd0, clen}, 16'd0, tag_next, 2'd0, 32'd0));
          end
        end
      end
      REQ_BULK: begin
        if (!cpend && mode_bulk_only) begin
          priority case (1'b1)
            tp == TP_CMD: begin
              if (done_endpoint != out_endpoint || !okc ||
                  bytes_moved != {16'd0, CBW_LEN}) begin
                fail = 1'b1;
              end else if (slen != 32'd0 && sbuf) begin
                if (|slen[31:16]) begin
                  tp_next = TP_IDLE;
                  bn = put(bn, mk(A_DONE, 8'd0, 16'd0, 16'd0, 32'd0, 2'd1, slen));
                end else begin
                  tp_next = TP_DATA;
                  bn = put(bn, mk(A_DATA, dep, slen[15:0], 16'd0, 32'd0, 2'd0, 32'd0));
                end
              end else begin
                tp_next = TP_STATUS;
                bn = put(bn, mk(A_CSW, in_endpoint, CSW_LEN, 16'd0, 32'd0, 2'd0, 32'd0));
              end
            end
            tp == TP_DATA: begin
              if (done_endpoint != dep || oc == OC_FAIL) begin
                fail = 1'b1;
              end else if (oc == OC_STALL) begin
                bn = put(bn, mk(A_UNSTALL, dep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
                bn = put(bn, mk(A_CLEAR, dep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
                cpend_next = 1'b1;
                tp_next = TP_STATUS;
              end else begin
                tp_next = TP_STATUS;
                bn = put(bn, mk(A_CSW, in_endpoint, CSW_LEN, 16'd0, 32'd0, 2'd0, 32'd0));
              end
            end
            tp == TP_STATUS || tp == TP_RETRY: begin
              if (done_endpoint != in_endpoint) begin
                fail = 1'b1;
              end else if (tp == TP_STATUS && okc && bytes_moved == 32'd0) begin
                tp_next = TP_RETRY;
                bn = put(bn, mk(A_CSW, in_endpoint, CSW_LEN, 16'd0, 32'd0, 2'd0, 32'd0));
              end else if (tp == TP_STATUS && oc == OC_STALL) begin
                bn = put(bn, mk(A_UNSTALL, in_endpoint, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
                bn = put(bn, mk(A_CLEAR, in_endpoint, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
                cpend_next = 1'b1;
                tp_next = TP_RETRY;
              end else if (!csw_ok) begin
                fail = 1'b1;
              end else begin
                tp_next = TP_IDLE;
                bn = put(bn, mk(A_DONE, 8'd0, 16'd0, 16'd0, 32'd0, status_code[1:0],
                                status_residue));
                startrec = (status_code == 8'd2);
              end
            end
            default: begin
            end
          endcase
        end else if (!cpend && tp == TP_DATA) begin
          if (oc == OC_FAIL && resid != 32'd0) begin
            bn = put(bn, mk(A_DATA, dep, resid[15:0], bytes_moved[15:0], 32'd0, 2'd0,
                            32'd0));
          end else begin
            if (oc == OC_STALL) begin
              bn = put(bn, mk(A_UNSTALL, dep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
            end
            tp_next = TP_IDLE;
            bn = put(bn, mk(A_DONE, 8'd0, 16'd0, 16'd0, 32'd0, {1'b0, !okc}, resid));
            startrec = !okc;
          end
        end
      end
      REQ_CTRL: begin
        if (rp != RC_IDLE) begin
          if (!okc && (rp == RC_CLR_IN || rp == RC_CLR_OUT)) begin
            if (rp == RC_CLR_IN) begin
              bn = put(bn, mk(A_UNSTALL, in_endpoint, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
            end
            bn = put(bn, mk(A_UNSTALL, out_endpoint, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
            rp_next = RC_IDLE;
          end else if (!okc || rp == RC_RESET) begin
            rp_next = RC_CLR_IN;
            bn = put(bn, mk(A_CLEAR, in_endpoint, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
          end else if (rp == RC_CLR_IN) begin
            bn = put(bn, mk(A_UNSTALL, in_endpoint, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
            rp_next = RC_CLR_OUT;
            bn = put(bn, mk(A_CLEAR, out_endpoint, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
          end else begin
            bn = put(bn, mk(A_UNSTALL, out_endpoint, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
            rp_next = RC_IDLE;
          end
        end else if (cpend) begin
          cpend_next = 1'b0;
          if (!okc) begin
            fail = 1'b1;
          end else begin
            tp_next = (tp == TP_RETRY) ? TP_RETRY : TP_STATUS;
            bn = put(bn, mk(A_CSW, in_endpoint, CSW_LEN, 16'd0, 32'd0, 2'd0, 32'd0));
          end
        end else if (!mode_bulk_only && tp == TP_CMD) begin
          if (!okc) begin
            tp_next = TP_IDLE;
            bn = put(bn, mk(A_DONE, 8'd0, 16'd0, 16'd0, 32'd0, 2'd1, slen));
          end else if (slen != 32'd0 && sbuf) begin
            if (|slen[31:16]) begin
              tp_next = TP_IDLE;
              bn = put(bn, mk(A_DONE, 8'd0, 16'd0, 16'd0, 32'd0, 2'd1, slen));
            end else begin
              tp_next = TP_DATA;
              bn = put(bn, mk(A_DATA, dep, slen[15:0], 16'd0, 32'd0, 2'd0, 32'd0));
            end
          end else begin
            tp_next = TP_IDLE;
            bn = put(bn, mk(A_DONE, 8'd0, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
          end
        end
      end
      REQ_ABORT: begin
        if (in_endpoint != 8'd0) begin
          if (rp != RC_IDLE || tp != TP_IDLE) begin
            if (rp != RC_IDLE || (tp == TP_CMD && !mode_bulk_only)) begin
              bn = put(bn, mk(A_ABORT, 8'd0, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
            end
            bn = put(bn, mk(A_ABORT, in_endpoint, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
            bn = put(bn, mk(A_ABORT, out_endpoint, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
            tp_next = TP_IDLE;
            cpend_next = 1'b0;
            rp_next = RC_IDLE;
            startrec = 1'b1;
          end
        end
      end
    endcase
    if (fail) begin
      tp_next = TP_IDLE;
      bn = put(bn, mk(A_DONE, 8'd0, 16'd0, 16'd0, 32'd0, 2'd1, slen));
      startrec = 1'b1;
    end
    if (startrec && in_endpoint != 8'd0 && rp_next == RC_IDLE) begin
      rp_next = RC_RESET;
      if (mode_bulk_only) begin
        bn = put(bn, mk(A_SRESET, 8'd0, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0));
      end else begin
        bn = put(bn, mk(A_DIAG, 8'd0, {11'd0, CB_CMD_LEN}, 16'd0, 32'd0, 2'd0, 32'd0));
      end
    end
    bn.rdy = (tp_next == TP_IDLE) && (rp_next == RC_IDLE);
  end

  assign push = accept && (bn.n != 3'd0);
  assign bundle = bn;

  always_ff @(posedge clk) begin
    if (rst) begin
      tp <= TP_IDLE;
      rp <= RC_IDLE;
      tag <= '0;
      slen <= '0;
      sdir <= 1'b0;
      sbuf <= 1'b0;
      cpend <= 1'b0;
    end else if (accept) begin
      tp <= tp_next;
      rp <= rp_next;
      tag <= tag_next;
      slen <= slen_next;
      sdir <= sdir_next;
      sbuf <= sbuf_next;
      cpend <= cpend_next;
    end
  end

endmodule

// ===== rtl/core/msts_back.sv =====
module msts_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  msts_pkg::bun_t bundle,
  output logic           full,
  output logic           ovalid,
  input  logic           oready,
  output msts_pkg::act_t oact,
  output logic           ordy,
  output logic           olast
);
  import msts_pkg::*;

  bun_t       mem [2];
  logic       wr;
  logic       rd;
  logic [1:0] cnt;
  logic [1:0] k;
  bun_t       head;
  logic       load;
  logic       fin;
  logic       pop;

  assign head = mem[rd];
  assign full = (cnt == 2'd2);
  assign load = (cnt != 2'd0) && (!ovalid || oready);
  assign fin = (({1'b0, k} + 3'd1) == head.n);
  assign pop = load && fin;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= 1'b0;
      rd <= 1'b0;
      cnt <= 2'd0;
      k <= 2'd0;
      ovalid <= 1'b0;
    end else begin
      if (push) begin
        wr <= ~wr;
      end
      if (pop) begin
        rd <= ~rd;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
      if (load) begin
        k <= fin ? 2'd0 : k + 2'd1;
        ovalid <= 1'b1;
      end else if (oready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      oact <= head.a[k];
      ordy <= head.rdy;
      olast <= fin;
    end
  end

endmodule

// ===== rtl/core/mass_storage_transport_sequencer_unit.sv =====
// Flow: an event is classified in the cycle it is taken; its actions are written
// into the two-entry action queue, then loaded into the output register, one
// action per cycle while m_axis_tready is high. Events are taken one per cycle
// while the queue is not full; each event yields at most four actions.
// Reset (rst, synchronous): phases idle, tag zero, queue and output empty,
// registers at mode bulk-only and all endpoints zero.
module mass_storage_transport_sequencer_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // data_length, dir_in, has_buffer, command_length, done_endpoint, xfer_outcome,
  // bytes_moved, status_signature, status_tag, status_code, status_residue
  input  logic [191:0]  s_axis_tdata,
  // req_type
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // action, action_endpoint, action_length, buffer_offset, command_tag,
  // done_status, done_residue, ready_res
  output logic [111:0]  m_axis_tdata,
  output logic          m_axis_tlast,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import msts_pkg::*;

  logic       mode_bulk_only;
  logic       subclass_ufi;
  logic [7:0] in_endpoint;
  logic [7:0] out_endpoint;
  logic [7:0] interface_number;
  logic       accept;
  logic       push;
  logic       full;
  bun_t       bundle;
  act_t       oact;
  logic       ordy;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bulk_only <= 1'b1;
      subclass_ufi <= 1'b0;
      in_endpoint <= '0;
      out_endpoint <= '0;
      interface_number <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MODE:   mode_bulk_only <= pwdata[0];
        REG_UFI:    subclass_ufi <= pwdata[0];
        REG_IN_EP:  in_endpoint <= pwdata[7:0];
        REG_OUT_EP: out_endpoint <= pwdata[7:0];
        REG_IFNUM:  interface_number <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MODE:   prdata = {31'd0, mode_bulk_only};
      REG_UFI:    prdata = {31'd0, subclass_ufi};
      REG_IN_EP:  prdata = {24'd0, in_endpoint};
      REG_OUT_EP: prdata = {24'd0, out_endpoint};
      REG_IFNUM:  prdata = {24'd0, interface_number};
      default:    prdata = 32'd0;
    endcase
  end

  assign s_axis_tready = !full;
  assign accept = s_axis_tvalid && s_axis_tready;

  msts_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .req_type         (s_axis_tuser),
    .data_length      (s_axis_tdata[31:0]),
    .dir_in           (s_axis_tdata[32]),
    .has_buffer       (s_axis_tdata[33]),
    .command_length   (s_axis_tdata[38:34]),
    .done_endpoint    (s_axis_tdata[46:39]),
    .xfer_outcome     (s_axis_tdata[48:47]),
    .bytes_moved      (s_axis_tdata[80:49]),
    .status_signature (s_axis_tdata[112:81]),
    .status_tag       (s_axis_tdata[144:113]),
    .status_code      (s_axis_tdata[152:145]),
    .status_residue   (s_axis_tdata[184:153]),
    .mode_bulk_only   (mode_bulk_only),
    .subclass_ufi     (subclass_ufi),
    .in_endpoint      (in_endpoint),
    .out_endpoint     (out_endpoint),
    .push             (push),
    .bundle           (bundle)
  );

  msts_back u_back (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .bundle (bundle),
    .full   (full),
    .ovalid (m_axis_tvalid),
    .oready (m_axis_tready),
    .oact   (oact),
    .ordy   (ordy),
    .olast  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, ordy, oact};

  a_reset_empty : assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
  a_action_range : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= A_REJECT)
    else $error("action code out of range");
  a_tag_only_cmd : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3:0] != A_CBW && m_axis_tdata[3:0] != A_ADSC
    |-> m_axis_tdata[75:44] == 32'd0)
    else $error("tag on non-command action");
  a_reject_alone : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3:0] == A_REJECT |-> m_axis_tlast)
    else $error("reject not alone");

endmodule

// ===== tb/mass_storage_transport_sequencer_unit_tb.sv =====
module mass_storage_transport_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msts_pkg::*;

  localparam logic [3:0] NO_ACTION = 4'hF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 150;

  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] data_length;
    logic        dir_in;
    logic        has_buffer;
    logic [4:0]  cmd_len;
    logic [7:0]  done_ep;
    logic [1:0]  outcome;
    logic [31:0] moved;
    logic [31:0] sig;
    logic [31:0] tag;
    logic [7:0]  code;
    logic [31:0] resid;
  } event_t;

  typedef struct packed {
    act_t a;
    logic rdy;
    logic last;
  } action_rec_t;

  typedef struct {
    event_t     e;
    logic [3:0] first_act;
    logic       stamp_tag;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic m_axis_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  mass_storage_transport_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sequencer mirror
  logic        cfg_bulk_only = 1'b1;
  logic        cfg_ufi = 1'b0;
  logic [7:0]  cfg_in_ep = '0;
  logic [7:0]  cfg_out_ep = '0;
  logic [7:0]  cfg_ifnum = '0;
  tp_t         xport = TP_IDLE;
  rc_t         recov = RC_IDLE;
  logic [31:0] tag_ctr = '0;
  logic [31:0] cur_len = '0;
  logic        cur_dir_in = 1'b0;
  logic        cur_buf = 1'b0;
  logic        clear_wait = 1'b0;
  logic [1:0]  last_status = '0;
  logic [31:0] last_residue = '0;

  action_rec_t step_actions[$];
  action_rec_t expected_actions[$];

  int mismatches = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit holdoff_due = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [7:0] data_ep();
    return cur_dir_in ? cfg_in_ep : cfg_out_ep;
  endfunction

  task automatic emit(logic [3:0] act, logic [7:0] ep, logic [15:0] len,
                      logic [15:0] off, logic [31:0] tag, logic [1:0] st,
                      logic [31:0] res);
    action_rec_t r;
    r.a.action = act;
    r.a.endpoint = ep;
    r.a.length = len;
    r.a.offset = off;
    r.a.tag = tag;
    r.a.status = st;
    r.a.residue = res;
    r.rdy = 1'b0;
    r.last = 1'b0;
    if (step_actions.size() < 4) step_actions.push_back(r);
  endtask

  task automatic finish_cmd(logic [1:0] st, logic [31:0] res);
    xport = TP_IDLE;
    last_status = st;
    last_residue = res;
    emit(A_DONE, 8'd0, 16'd0, 16'd0, 32'd0, st, res);
  endtask

  task automatic begin_recovery();
    if (cfg_in_ep != 0 && recov == RC_IDLE) begin
      recov = RC_RESET;
      if (cfg_bulk_only) emit(A_SRESET, 8'd0, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
      else emit(A_DIAG, 8'd0, 16'(CB_CMD_LEN), 16'd0, 32'd0, 2'd0, 32'd0);
    end
  endtask

  task automatic fail_recover();
    finish_cmd(2'd1, cur_len);
    begin_recovery();
  endtask

  task automatic begin_data();
    if (cur_len > 32'hFFFF) begin
      finish_cmd(2'd1, cur_len);
    end else begin
      xport = TP_DATA;
      emit(A_DATA, data_ep(), cur_len[15:0], 16'd0, 32'd0, 2'd0, 32'd0);
    end
  endtask

  task automatic read_status(tp_t ph);
    xport = ph;
    emit(A_CSW, cfg_in_ep, CSW_LEN, 16'd0, 32'd0, 2'd0, 32'd0);
  endtask

  task automatic bulk_only_done(event_t e, logic [1:0] oc);
    bit good;
    case (xport)
      TP_CMD: begin
        if (e.done_ep != cfg_out_ep || oc != OC_OK || e.moved != 32'(CBW_LEN)) fail_recover();
        else if (cur_len != 0 && cur_buf) begin_data();
        else read_status(TP_STATUS);
      end
      TP_DATA: begin
        if (e.done_ep != data_ep() || oc == OC_FAIL) begin
          fail_recover();
        end else if (oc == OC_STALL) begin
          emit(A_UNSTALL, data_ep(), 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
          emit(A_CLEAR, data_ep(), 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
          clear_wait = 1'b1;
          xport = TP_STATUS;
        end else begin
          read_status(TP_STATUS);
        end
      end
      TP_STATUS, TP_RETRY: begin
        if (e.done_ep != cfg_in_ep) begin
          fail_recover();
        end else if (xport == TP_STATUS && oc == OC_OK && e.moved == 0) begin
          read_status(TP_RETRY);
        end else if (xport == TP_STATUS && oc == OC_STALL) begin
          emit(A_UNSTALL, cfg_in_ep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
          emit(A_CLEAR, cfg_in_ep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
          clear_wait = 1'b1;
          xport = TP_RETRY;
        end else begin
          good = oc == OC_OK && e.moved == 32'(CSW_LEN) && e.sig == CSW_SIG &&
                 e.tag == tag_ctr && e.code <= 2 && e.resid <= cur_len;
          if (!good) begin
            fail_recover();
          end else begin
            finish_cmd(e.code[1:0], e.resid);
            if (e.code == 2) begin_recovery();
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic ctrl_bulk_done(event_t e, logic [1:0] oc);
    logic [31:0] left;
    if (xport == TP_DATA) begin
      left = (e.moved <= cur_len) ? cur_len - e.moved : 32'd0;
      if (oc == OC_FAIL && left > 0) begin
        emit(A_DATA, data_ep(), left[15:0], e.moved[15:0], 32'd0, 2'd0, 32'd0);
      end else begin
        if (oc == OC_STALL) emit(A_UNSTALL, data_ep(), 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
        finish_cmd(oc == OC_OK ? 2'd0 : 2'd1, left);
        if (oc != OC_OK) begin_recovery();
      end
    end
  endtask

  task automatic control_done(bit ok);
    rc_t rp;
    rp = recov;
    if (rp != RC_IDLE) begin
      if (!ok && (rp == RC_CLR_IN || rp == RC_CLR_OUT)) begin
        if (rp == RC_CLR_IN) emit(A_UNSTALL, cfg_in_ep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
        emit(A_UNSTALL, cfg_out_ep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
        recov = RC_IDLE;
      end else if (!ok || rp == RC_RESET) begin
        recov = RC_CLR_IN;
        emit(A_CLEAR, cfg_in_ep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
      end else if (rp == RC_CLR_IN) begin
        emit(A_UNSTALL, cfg_in_ep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
        recov = RC_CLR_OUT;
        emit(A_CLEAR, cfg_out_ep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
      end else begin
        emit(A_UNSTALL, cfg_out_ep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
        recov = RC_IDLE;
      end
    end else if (clear_wait) begin
      clear_wait = 1'b0;
      if (!ok) fail_recover();
      else read_status(xport == TP_RETRY ? TP_RETRY : TP_STATUS);
    end else if (!cfg_bulk_only && xport == TP_CMD) begin
      if (!ok) finish_cmd(2'd1, cur_len);
      else if (cur_len != 0 && cur_buf) begin_data();
      else finish_cmd(2'd0, 32'd0);
    end
  endtask

  task automatic abort_transfers();
    if (cfg_in_ep != 0) begin
      if (recov != RC_IDLE) begin
        emit(A_ABORT, 8'd0, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
        emit(A_ABORT, cfg_in_ep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
        emit(A_ABORT, cfg_out_ep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
        xport = TP_IDLE;
        clear_wait = 1'b0;
        recov = RC_IDLE;
        begin_recovery();
      end else if (xport != TP_IDLE) begin
        if (xport == TP_CMD && !cfg_bulk_only)
          emit(A_ABORT, 8'd0, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
        emit(A_ABORT, cfg_in_ep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
        emit(A_ABORT, cfg_out_ep, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
        xport = TP_IDLE;
        clear_wait = 1'b0;
        begin_recovery();
      end
    end
  endtask

  task automatic sequence_event(event_t e);
    logic [1:0] oc;
    logic [4:0] clen;
    bit rdy;
    step_actions.delete();
    oc = (e.outcome == 2'd3) ? OC_FAIL : e.outcome;
    case (e.req)
      REQ_SUBMIT: begin
        if (cfg_in_ep == 0 || xport != TP_IDLE) begin
          emit(A_REJECT, 8'd0, 16'd0, 16'd0, 32'd0, 2'd0, 32'd0);
        end else begin
          tag_ctr = tag_ctr + 1;
          if (tag_ctr == 0) tag_ctr = 1;
          cur_len = e.data_length;
          cur_dir_in = e.dir_in;
          cur_buf = e.has_buffer;
          xport = TP_CMD;
          if (cfg_bulk_only) begin
            emit(A_CBW, cfg_out_ep, CBW_LEN, 16'd0, tag_ctr, 2'd0, 32'd0);
          end else begin
            clen = (e.cmd_len > CB_CMD_LEN || cfg_ufi) ? CB_CMD_LEN : e.cmd_len;
            emit(A_ADSC, 8'd0, 16'(clen), 16'd0, tag_ctr, 2'd0, 32'd0);
          end
        end
      end
      REQ_BULK: begin
        if (!clear_wait) begin
          if (cfg_bulk_only) bulk_only_done(e, oc);
          else ctrl_bulk_done(e, oc);
        end
      end
      REQ_CTRL: control_done(oc == OC_OK);
      default: abort_transfers();
    endcase
    rdy = (xport == TP_IDLE && recov == RC_IDLE);
    foreach (step_actions[k]) begin
      step_actions[k].rdy = rdy;
      step_actions[k].last = (k == step_actions.size() - 1);
      expected_actions.push_back(step_actions[k]);
    end
  endtask

  function automatic logic [191:0] pack_event(event_t e);
    return {7'd0, e.resid, e.code, e.tag, e.sig, e.moved, e.outcome, e.done_ep,
            e.cmd_len, e.has_buffer, e.dir_in, e.data_length};
  endfunction

  function automatic event_t noise_event();
    event_t e;
    e.req = 2'($urandom_range(0, 3));
    e.data_length = $urandom;
    e.dir_in = 1'($urandom);
    e.has_buffer = 1'($urandom);
    e.cmd_len = 5'($urandom_range(0, 16));
    e.done_ep = 8'($urandom);
    e.outcome = 2'($urandom_range(0, 3));
    e.moved = $urandom;
    e.sig = $urandom;
    e.tag = $urandom;
    e.code = 8'($urandom);
    e.resid = $urandom;
    return e;
  endfunction

  function automatic event_t next_event();
    event_t e;
    int pick;
    e = noise_event();
    pick = $urandom_range(0, 99);
    if (pick < 12) return e;
    if (pick < 15) begin
      e.req = REQ_ABORT;
      return e;
    end
    e.outcome = ($urandom_range(0, 9) < 8) ? OC_OK : 2'($urandom_range(1, 3));
    if (recov != RC_IDLE || clear_wait) begin
      e.req = ($urandom_range(0, 9) < 8) ? REQ_CTRL : REQ_SUBMIT;
    end else if (xport == TP_IDLE) begin
      e.req = REQ_SUBMIT;
      pick = $urandom_range(0, 99);
      if (pick < 60) e.data_length = $urandom_range(1, 600);
      else if (pick < 75) e.data_length = 0;
      else if (pick < 85) e.data_length = $urandom_range(65536, 70000);
      else if (pick < 90) e.data_length = 32'hFFFF;
      e.has_buffer = ($urandom_range(0, 9) < 8);
    end else if (!cfg_bulk_only) begin
      e.req = (xport == TP_CMD) ? REQ_CTRL : REQ_BULK;
      e.moved = $urandom_range(0, cur_len[15:0] + 1);
    end else begin
      e.req = REQ_BULK;
      case (xport)
        TP_CMD: begin
          e.done_ep = cfg_out_ep;
          if ($urandom_range(0, 9) < 9) e.moved = 32'(CBW_LEN);
        end
        TP_DATA: begin
          e.done_ep = data_ep();
          e.moved = $urandom_range(0, cur_len[15:0]);
        end
        default: begin
          e.done_ep = cfg_in_ep;
          pick = $urandom_range(0, 9);
          if (pick == 0) e.moved = 0;
          else if (pick < 9) e.moved = 32'(CSW_LEN);
          if ($urandom_range(0, 9) < 9) e.sig = CSW_SIG;
          if ($urandom_range(0, 9) < 9) e.tag = tag_ctr;
          if ($urandom_range(0, 9) < 8) e.code = 8'($urandom_range(0, 2));
          if ($urandom_range(0, 9) < 8) e.resid = $urandom_range(0, cur_len[15:0]);
        end
      endcase
    end
    return e;
  endfunction

  function automatic event_t mk_event(logic [1:0] req, logic [31:0] bytes, logic dir,
                                      logic bufr, logic [7:0] ep, logic [1:0] oc,
                                      logic [31:0] moved, logic [7:0] code,
                                      logic [31:0] res);
    event_t e;
    e = '0;
    e.req = req;
    e.data_length = bytes;
    e.dir_in = dir;
    e.has_buffer = bufr;
    e.cmd_len = 5'd16;
    e.done_ep = ep;
    e.outcome = oc;
    e.moved = moved;
    e.sig = CSW_SIG;
    e.code = code;
    e.resid = res;
    return e;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE: cfg_bulk_only = val[0];
      REG_UFI: cfg_ufi = val[0];
      REG_IN_EP: cfg_in_ep = val[7:0];
      REG_OUT_EP: cfg_out_ep = val[7:0];
      default: cfg_ifnum = val[7:0];
    endcase
  endtask

  task automatic transfer_event(event_t e);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pack_event(e);
    s_axis_tuser <= e.req;
    do @(posedge clk); while (!s_axis_tready);
    sequence_event(e);
    items_sent++;
    if (items_sent == 100) holdoff_due = 1'b1;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    action_rec_t want;
    act_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = act_t'(m_axis_tdata[109:0]);
      if (expected_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected action %h", m_axis_tdata);
      end else begin
        want = expected_actions.pop_front();
        if (got.action != want.a.action || got.endpoint != want.a.endpoint ||
            got.length != want.a.length || got.offset != want.a.offset ||
            got.tag != want.a.tag || got.status != want.a.status ||
            got.residue != want.a.residue || m_axis_tdata[110] != want.rdy ||
            m_axis_tdata[111] != 1'b0 || m_axis_tlast != want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("action mismatch: expected %h rdy %b last %b, got %h last %b",
                     want.a, want.rdy, want.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    int n;
    @(posedge clk);
    while (!stim_done) begin
      if (calm) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else if (holdoff_due) begin
        holdoff_due = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 8);
        m_axis_tready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
    m_axis_tready <= 1'b1;
  end

  initial begin
    script_row_t script[$];
    script_row_t row;
    event_t e;
    int limit;
    logic [7:0] in_ep_pick;
    logic [3:0] first_got;

    row.stamp_tag = 1'b0;
    row.e = mk_event(REQ_SUBMIT, 32'd8, 1, 1, 0, OC_OK, 0, 0, 0);
    row.first_act = A_REJECT; script.push_back(row);
    row.e = mk_event(REQ_ABORT, 0, 0, 0, 0, OC_OK, 0, 0, 0);
    row.first_act = NO_ACTION; script.push_back(row);
    row.e = mk_event(REQ_SUBMIT, 32'd512, 1, 1, 0, OC_OK, 0, 0, 0);
    row.first_act = A_CBW; script.push_back(row);
    row.e = mk_event(REQ_BULK, 0, 0, 0, 8'h02, OC_OK, 32'd31, 0, 0);
    row.first_act = A_DATA; script.push_back(row);
    row.e = mk_event(REQ_BULK, 0, 0, 0, 8'h81, OC_OK, 32'd512, 0, 0);
    row.first_act = A_CSW; script.push_back(row);
    row.e = mk_event(REQ_BULK, 0, 0, 0, 8'h81, OC_OK, 32'd13, 0, 0);
    row.first_act = A_DONE; row.stamp_tag = 1'b1; script.push_back(row);
    row.stamp_tag = 1'b0;
    row.e = mk_event(REQ_SUBMIT, 0, 0, 0, 0, OC_OK, 0, 0, 0);
    row.first_act = A_CBW; script.push_back(row);
    row.e = mk_event(REQ_BULK, 0, 0, 0, 8'h02, OC_OK, 32'd31, 0, 0);
    row.first_act = A_CSW; script.push_back(row);
    row.e = mk_event(REQ_BULK, 0, 0, 0, 8'h81, OC_OK, 32'd0, 0, 0);
    row.first_act = A_CSW; script.push_back(row);
    row.e = mk_event(REQ_BULK, 0, 0, 0, 8'h81, OC_STALL, 32'd0, 0, 0);
    row.first_act = A_DONE; script.push_back(row);
    row.e = mk_event(REQ_CTRL, 0, 0, 0, 0, OC_OK, 0, 0, 0);
    row.first_act = A_CLEAR; script.push_back(row);
    row.first_act = A_UNSTALL; script.push_back(row);
    row.first_act = A_UNSTALL; script.push_back(row);
    row.e = mk_event(REQ_SUBMIT, 32'h10000, 0, 1, 0, OC_OK, 0, 0, 0);
    row.first_act = A_CBW; script.push_back(row);
    row.e = mk_event(REQ_BULK, 0, 0, 0, 8'h02, OC_OK, 32'd31, 0, 0);
    row.first_act = A_DONE; script.push_back(row);
    row.e = mk_event(REQ_SUBMIT, 32'hFFFF_FFFF, 1, 1, 0, OC_OK, 0, 0, 0);
    row.first_act = A_CBW; script.push_back(row);
    row.first_act = A_REJECT; script.push_back(row);
    row.e = mk_event(REQ_ABORT, 0, 0, 0, 0, OC_OK, 0, 0, 0);
    row.first_act = A_ABORT; script.push_back(row);
    row.e = mk_event(REQ_CTRL, 0, 0, 0, 0, 2'd3, 0, 0, 0);
    row.first_act = A_CLEAR; script.push_back(row);
    row.first_act = A_UNSTALL; script.push_back(row);
    row.e = mk_event(REQ_SUBMIT, 32'd100, 1, 1, 0, OC_OK, 0, 0, 0);
    row.first_act = A_CBW; script.push_back(row);
    row.e = mk_event(REQ_BULK, 0, 0, 0, 8'h02, OC_OK, 32'd31, 0, 0);
    row.first_act = A_DATA; script.push_back(row);
    row.e = mk_event(REQ_BULK, 0, 0, 0, 8'h81, OC_STALL, 32'd0, 0, 0);
    row.first_act = A_UNSTALL; script.push_back(row);
    row.e = mk_event(REQ_CTRL, 0, 0, 0, 0, OC_OK, 0, 0, 0);
    row.first_act = A_CSW; script.push_back(row);
    row.e = mk_event(REQ_BULK, 0, 0, 0, 8'h81, OC_OK, 32'd13, 8'd2, 32'd5);
    row.first_act = A_DONE; row.stamp_tag = 1'b1; script.push_back(row);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (i == 2) begin
        drain();
        reg_write(REG_MODE, 32'd1);
        reg_write(REG_UFI, 32'd0);
        reg_write(REG_IN_EP, 32'h81);
        reg_write(REG_OUT_EP, 32'h02);
        reg_write(REG_IFNUM, 32'h5A);
      end
      e = script[i].e;
      if (script[i].stamp_tag) e.tag = tag_ctr;
      transfer_event(e);
      first_got = (step_actions.size() == 0) ? NO_ACTION : step_actions[0].a.action;
      if (first_got != script[i].first_act) begin
        mismatches++;
        if (mismatches <= 10)
          $display("step %0d: expected first action %0d, got %0d", i,
                   script[i].first_act, first_got);
      end
    end

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: in_ep_pick = 8'hFF;
        1: in_ep_pick = 8'h00;
        2: in_ep_pick = 8'h01;
        default: in_ep_pick = 8'($urandom_range(1, 255));
      endcase
      reg_write(REG_MODE, 32'(ph % 2));
      reg_write(REG_UFI, (ph == 3 || ph == 5) ? 32'd1 : 32'd0);
      reg_write(REG_IN_EP, {24'd0, in_ep_pick});
      reg_write(REG_OUT_EP, ph == 0 ? 32'h00 : (ph == 2 ? 32'hFF : $urandom_range(0, 255)));
      reg_write(REG_IFNUM, ph == 0 ? 32'h00 : (ph == 4 ? 32'hFF : $urandom_range(0, 255)));
      calm = (ph == 6);
      limit = (ph == 1) ? 16 : 56;
      for (int k = 0; k < limit; k++) transfer_event(next_event());
    end
    s_axis_tvalid <= 1'b0;

    while (expected_actions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    stim_done = 1'b1;
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== mass_storage_transport_sequencer_unit.f =====
rtl/core/msts_pkg.sv
rtl/core/msts_front.sv
rtl/core/msts_back.sv
rtl/core/mass_storage_transport_sequencer_unit.sv
tb/mass_storage_transport_sequencer_unit_tb.sv
